[sv/sorted_key_set_unit_defines.svh]
// assertion macros for the sorted key set unit
// used by files that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef SORTED_KEY_SET_UNIT_DEFINES_SVH
`define SORTED_KEY_SET_UNIT_DEFINES_SVH

// antecedent implies consequent on the same edge, checked outside reset
`define SKSET_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen outside reset
`define SKSET_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[sv/skset_pkg.sv]
// shared types and constants for the sorted key set unit
// no dependencies
package skset_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_OUT_W = 9;

    typedef enum logic [1:0] {
        ACT_QUERY   = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_INSERT  = 2'd2,
        ACT_INVALID = 2'd3
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic signed [KEY_W-1:0]  key;
    } t_skset_in;

    typedef struct packed {
        logic                     success;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_skset_out;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_MOVE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_DONE
    } t_state;

endpackage

[sv/skset_mem.sv]
// key storage: one write port, one read port with registered read data
// depends on skset_pkg
module skset_mem
    import skset_pkg::*;
#(
    parameter int CAPACITY = 256,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [KEY_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [KEY_W-1:0] o_rdata
);

    logic signed [KEY_W-1:0] r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/skset_cmp.sv]
// shared signed key comparator used by every search step
// depends on skset_pkg
module skset_cmp
    import skset_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_a,
    input  logic signed [KEY_W-1:0] i_b,
    output t_cmp_res                o_res
);

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

[sv/skset_seq.sv]
// sequencer: binary search for the lower bound, then entry shifts for insert/remove
// depends on skset_pkg, skset_cmp, sorted_key_set_unit_defines.svh
`include "sorted_key_set_unit_defines.svh"

module skset_seq
    import skset_pkg::*;
#(
    parameter int CAPACITY = 256,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_skset_in               i_in,
    output logic                    o_res_valid,
    input  logic                    i_res_take,
    output t_skset_out              o_res,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic signed [KEY_W-1:0] o_wdata,
    output logic                    o_re,
    output logic [AW-1:0]           o_raddr,
    input  logic signed [KEY_W-1:0] i_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state                  r_state, n_state;
    t_action                 r_act;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_found, n_found;
    logic                    r_ok, n_ok;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    t_cmp_res      cmp;
    logic          do_remove;
    logic          do_insert;
    logic          more_shift;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];

    skset_cmp u_cmp (
        .i_a   (i_rdata),
        .i_b   (r_key),
        .o_res (cmp)
    );

    assign do_remove  = (r_act == ACT_REMOVE) && r_ok;
    assign do_insert  = (r_act == ACT_INSERT) && r_ok;
    assign more_shift = do_remove ? ((r_idx + ONE_C) < r_count) : (r_idx > r_lo);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PROBE;
            S_PROBE: n_state = (r_lo < r_hi) ? S_CMP : S_MOVE;
            S_CMP:   n_state = S_PROBE;
            S_MOVE: begin
                if ((do_remove || do_insert) && more_shift) begin
                    n_state = S_SH_RD;
                end else if (do_insert) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = S_MOVE;
            S_PUT:   n_state = S_DONE;
            S_DONE:  if (i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_idx[AW-1:0];
        o_wdata     = i_rdata;
        o_re        = 1'b0;
        o_raddr     = mid[AW-1:0];
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_count     = r_count;
        n_found     = r_found;
        n_ok        = r_ok;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_lo       = '0;
                n_hi       = r_count;
                n_found    = 1'b0;
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    o_re = 1'b1;
                end else begin
                    n_idx = (r_act == ACT_INSERT) ? r_count : r_lo;
                    case (r_act)
                        ACT_QUERY:  n_ok = r_found;
                        ACT_REMOVE: n_ok = r_found;
                        ACT_INSERT: n_ok = !r_found && (r_count < CAP_C);
                        default:    n_ok = 1'b0;
                    endcase
                end
            end
            S_CMP: begin
                if (cmp.lt) begin
                    n_lo = mid + ONE_C;
                end else begin
                    n_hi = mid;
                end
                if (cmp.eq) begin
                    n_found = 1'b1;
                end
            end
            S_MOVE: begin
                if (do_remove && !more_shift) begin
                    n_count = r_count - ONE_C;
                end
            end
            S_SH_RD: begin
                o_re    = 1'b1;
                o_raddr = do_remove ? AW'(r_idx + ONE_C) : AW'(r_idx - ONE_C);
            end
            S_SH_WR: begin
                o_we  = 1'b1;
                n_idx = do_remove ? (r_idx + ONE_C) : (r_idx - ONE_C);
            end
            S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_lo[AW-1:0];
                o_wdata = r_key;
                n_count = r_count + ONE_C;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_res.success     = r_ok;
    assign o_res.entry_count = CNT_OUT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_ok    <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_act <= i_in.action;
            r_key <= i_in.key;
        end
    end

    `SKSET_NEVER(a_count_bound, r_count > CAP_C, "entry count above capacity")
    `SKSET_NEVER(a_window_order, r_lo > r_hi || r_hi > r_count,
        "search window out of order")
    `SKSET_CHECK(a_idle_count_hold, r_state == S_IDLE && $past(r_state) == S_IDLE,
        $stable(r_count), "entry count moved while idle")
    `SKSET_CHECK(a_write_phase, o_we, r_state == S_SH_WR || r_state == S_PUT,
        "memory write outside a shift or put step")

endmodule

[sv/sorted_key_set_unit.sv]
// Sorted key set: holds up to CAPACITY distinct signed 32-bit keys in ascending
// order and answers query, remove and insert transactions with a success flag and
// the count held afterwards. One transaction is handled at a time: a binary search
// over the key memory finds the place, probe by probe, and a remove or insert then
// moves every entry above the found place through the memory, each read and then
// written back. A new transaction is taken while the previous result still waits
// in the output register.
// depends on skset_pkg, skset_seq, skset_mem
module sorted_key_set_unit
    import skset_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_skset_in  i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_skset_out o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                    res_valid;
    logic                    res_take;
    t_skset_out              res;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [KEY_W-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic signed [KEY_W-1:0] rdata;

    logic       r_out_valid;
    t_skset_out r_out;

    skset_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    skset_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output slot frees up when empty or being drained this cycle
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[tb/sorted_key_set_unit_tb.sv]
// testbench for sorted_key_set_unit: directed, full-table and random set transactions
// keeps a mirror of the key set and checks every result against it; needs skset_pkg
`timescale 1ns / 100ps

module sorted_key_set_unit_tb;
    import skset_pkg::*;

    localparam int CAPACITY = 256;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_skset_in  i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_skset_out o_out;

    // mirror of the held keys, ascending
    logic signed [KEY_W-1:0] mirror_keys[$];
    t_skset_out              expected_replies[$];
    int                      mismatch_count = 0;
    bit                      idle_off = 1'b0;

    sorted_key_set_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // apply one transaction to the mirror and return the result it must give
    function automatic t_skset_out predict_set_action(input t_skset_in item);
        t_skset_out              res;
        logic signed [KEY_W-1:0] k;
        int                      pos;
        bit                      present;
        bit                      ok;
        k = item.key;
        pos = 0;
        ok = 1'b0;
        while (pos < mirror_keys.size() && mirror_keys[pos] < k)
            pos++;
        present = (pos < mirror_keys.size()) && (mirror_keys[pos] == k);
        case (item.action)
            ACT_QUERY: begin
                ok = present;
            end
            ACT_REMOVE: begin
                if (present) begin
                    mirror_keys.delete(pos);
                    ok = 1'b1;
                end
            end
            ACT_INSERT: begin
                if (!present && mirror_keys.size() < CAPACITY) begin
                    mirror_keys.insert(pos, k);
                    ok = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        res.success = ok;
        res.entry_count = CNT_OUT_W'(mirror_keys.size());
        return res;
    endfunction

    // entered and left at a falling edge; valid stays high after the transaction
    task automatic issue_set_action(input t_action act, input logic signed [KEY_W-1:0] key);
        t_skset_in item;
        item.action = act;
        item.key = key;
        while (!idle_off && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_replies.push_back(predict_set_action(item));
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (idle_off)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        t_skset_out exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 100)
                    $display("%0t: unexpected result, expected none actual %p", $time, o_out);
            end else begin
                exp_res = expected_replies.pop_front();
                if (o_out.success !== exp_res.success) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: success mismatch, expected %0b actual %0b",
                                 $time, exp_res.success, o_out.success);
                end
                if (o_out.entry_count !== exp_res.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: entry_count mismatch, expected %0d actual %0d",
                                 $time, exp_res.entry_count, o_out.entry_count);
                end
            end
        end
    end

    // extremes of the key, every action, duplicates, absent keys, invalid action
    task automatic test_basic_actions;
        issue_set_action(ACT_QUERY, KEY_MIN);
        issue_set_action(ACT_REMOVE, 32'sd5);
        issue_set_action(ACT_INVALID, 32'sd0);
        issue_set_action(ACT_INSERT, 32'sd0);
        issue_set_action(ACT_INSERT, KEY_MIN);
        issue_set_action(ACT_INSERT, KEY_MAX);
        issue_set_action(ACT_INSERT, -32'sd1);
        issue_set_action(ACT_INSERT, 32'sd1);
        issue_set_action(ACT_INSERT, 32'sd0);
        issue_set_action(ACT_QUERY, KEY_MIN);
        issue_set_action(ACT_QUERY, KEY_MAX);
        issue_set_action(ACT_QUERY, 32'sd2);
        issue_set_action(ACT_INVALID, KEY_MAX);
        issue_set_action(ACT_QUERY, KEY_MAX);
        issue_set_action(ACT_REMOVE, KEY_MAX);
        issue_set_action(ACT_REMOVE, KEY_MAX);
        issue_set_action(ACT_REMOVE, KEY_MIN);
        issue_set_action(ACT_QUERY, KEY_MIN);
        issue_set_action(ACT_INSERT, 32'sh5555_5555);
        issue_set_action(ACT_INSERT, 32'shaaaa_aaaa);
        issue_set_action(ACT_QUERY, 32'shaaaa_aaaa);
        while (mirror_keys.size() > 0)
            issue_set_action(ACT_REMOVE, mirror_keys[0]);
    endtask

    // fill to capacity, hit the full-table case, then drain in random order
    task automatic test_full_table;
        int n;
        while (mirror_keys.size() < CAPACITY) begin
            n++;
            if (n % 16 == 0)
                issue_set_action(ACT_INSERT,
                                 mirror_keys[$urandom_range(0, mirror_keys.size() - 1)]);
            else
                issue_set_action(ACT_INSERT, $urandom);
        end
        issue_set_action(ACT_INSERT, $urandom);
        issue_set_action(ACT_INSERT, mirror_keys[0]);
        issue_set_action(ACT_QUERY, mirror_keys[CAPACITY - 1]);
        issue_set_action(ACT_INVALID, mirror_keys[3]);
        issue_set_action(ACT_REMOVE, mirror_keys[CAPACITY / 2]);
        issue_set_action(ACT_INSERT, $urandom);
        issue_set_action(ACT_INSERT, $urandom);
        while (mirror_keys.size() > 0)
            issue_set_action(ACT_REMOVE,
                             mirror_keys[$urandom_range(0, mirror_keys.size() - 1)]);
    endtask

    // random transactions over small key pools so that hits are common
    task automatic test_random_mix;
        logic signed [KEY_W-1:0] key_pool[64];
        int                      pool_n;
        int                      pick;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < 64; i++)
            key_pool[i] = $urandom;
        for (int blk = 0; blk < 4; blk++) begin
            pool_n = $urandom_range(4, 64);
            idle_off = (blk == 2);
            for (int i = 0; i < 200; i++) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    issue_set_action(t_action'($urandom_range(0, 3)), $urandom);
                else if (pick < 10)
                    issue_set_action(ACT_INVALID, key_pool[$urandom_range(0, pool_n - 1)]);
                else if (pick < 45)
                    issue_set_action(ACT_INSERT, key_pool[$urandom_range(0, pool_n - 1)]);
                else if (pick < 75)
                    issue_set_action(ACT_REMOVE, key_pool[$urandom_range(0, pool_n - 1)]);
                else
                    issue_set_action(ACT_QUERY, key_pool[$urandom_range(0, pool_n - 1)]);
            end
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_actions();
        test_full_table();
        test_random_mix();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sorted_key_set_unit_tb: clean");
        else
            $display("sorted_key_set_unit_tb: errors");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("sorted_key_set_unit_tb: errors");
        $finish;
    end

endmodule
